### src/slm_pkg.sv
// slm_pkg: shared constants, command codes and control/status types for the
// sorted list merge block. No dependencies.
`default_nettype none

package slm_pkg;

    localparam int WORD_W         = 32;
    localparam int FUNC_W         = 2;
    localparam int LIST_DEPTH_DEF = 16;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_FIRST  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_SECOND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MERGE       = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push_first;
        logic push_second;
        logic emit_empty;
        logic step;
    } slm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic total_zero;
        logic last_take;
    } slm_status_t;

endpackage

`default_nettype wire

### src/slm_ram.sv
// slm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module slm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/slm_ctrl.sv
// slm_ctrl: command decode and merge sequencer for the sorted list merge.
// Depends on slm_pkg.
`default_nettype none

module slm_ctrl
    import slm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [FUNC_W-1:0] func,
    input  wire slm_status_t       status,
    output logic                   busy,
    output slm_cmd_t               cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EMIT = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        FUNC_PUSH_FIRST:  cmd.push_first  = 1'b1;
                        FUNC_PUSH_SECOND: cmd.push_second = 1'b1;
                        FUNC_MERGE:
                        begin
                            if (status.total_zero)
                            begin
                                cmd.emit_empty = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EMIT:
            begin
                cmd.step   = 1'b1;
                state_next = status.last_take ? ST_IDLE : ST_WAIT;
            end
            ST_WAIT:
            begin
                // Let the RAMs fetch the advanced head.
                state_next = ST_EMIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

### src/slm_dp.sv
// slm_dp: list stores, fill counts, merge heads, compare and result registers.
// Depends on slm_pkg and slm_ram.
`default_nettype none

module slm_dp
    import slm_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire slm_cmd_t                 cmd,
    input  wire logic signed [WORD_W-1:0] value,
    output slm_status_t                   status,
    output logic                          strobe,
    output logic signed [WORD_W-1:0]      merged_value,
    output logic                          last,
    output logic                          empty_res,
    output logic                          overflow
);

    localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    logic [CNT_W-1:0] cnt1_reg, cnt1_next;
    logic [CNT_W-1:0] cnt2_reg, cnt2_next;
    logic [CNT_W-1:0] idx1_reg, idx1_next;
    logic [CNT_W-1:0] idx2_reg, idx2_next;
    logic             dropped_reg, dropped_next;
    logic             strobe_reg, strobe_next;

    logic signed [WORD_W-1:0] value_reg, value_next;
    logic                     last_reg, last_next;
    logic                     empty_reg, empty_next;
    logic                     ovf_reg, ovf_next;

    logic [WORD_W-1:0] head1;
    logic [WORD_W-1:0] head2;
    logic              we1;
    logic              we2;
    logic              has1;
    logic              has2;
    logic              take_first;
    logic              last_take;

    assign we1 = cmd.push_first  && (cnt1_reg != FULL);
    assign we2 = cmd.push_second && (cnt2_reg != FULL);

    slm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LIST_DEPTH)
    ) u_first_ram (
        .clk   (clk),
        .we    (we1),
        .waddr (cnt1_reg[ADDR_W-1:0]),
        .wdata (value),
        .raddr (idx1_reg[ADDR_W-1:0]),
        .rdata (head1)
    );

    slm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LIST_DEPTH)
    ) u_second_ram (
        .clk   (clk),
        .we    (we2),
        .waddr (cnt2_reg[ADDR_W-1:0]),
        .wdata (value),
        .raddr (idx2_reg[ADDR_W-1:0]),
        .rdata (head2)
    );

    assign has1 = (idx1_reg < cnt1_reg);
    assign has2 = (idx2_reg < cnt2_reg);

    // Ties go to the first list.
    assign take_first = (has1 && has2) ? ($signed(head1) <= $signed(head2)) : has1;
    assign last_take  = take_first
                        ? ((idx1_reg + ONE == cnt1_reg) && (idx2_reg == cnt2_reg))
                        : ((idx1_reg == cnt1_reg) && (idx2_reg + ONE == cnt2_reg));

    assign status.total_zero = (cnt1_reg == '0) && (cnt2_reg == '0);
    assign status.last_take  = last_take;

    always_comb
    begin
        cnt1_next    = cnt1_reg;
        cnt2_next    = cnt2_reg;
        idx1_next    = idx1_reg;
        idx2_next    = idx2_reg;
        dropped_next = dropped_reg;
        strobe_next  = 1'b0;
        value_next   = value_reg;
        last_next    = last_reg;
        empty_next   = empty_reg;
        ovf_next     = ovf_reg;

        if (cmd.push_first)
        begin
            if (we1)
            begin
                cnt1_next = cnt1_reg + ONE;
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end

        if (cmd.push_second)
        begin
            if (we2)
            begin
                cnt2_next = cnt2_reg + ONE;
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end

        if (cmd.emit_empty)
        begin
            strobe_next  = 1'b1;
            value_next   = '0;
            last_next    = 1'b1;
            empty_next   = 1'b1;
            ovf_next     = dropped_reg;
            dropped_next = 1'b0;
        end

        if (cmd.step)
        begin
            strobe_next = 1'b1;
            value_next  = take_first ? $signed(head1) : $signed(head2);
            last_next   = last_take;
            empty_next  = 1'b0;
            ovf_next    = dropped_reg;
            if (take_first)
            begin
                idx1_next = idx1_reg + ONE;
            end
            else
            begin
                idx2_next = idx2_reg + ONE;
            end
            if (last_take)
            begin
                // Drop both lists and the sticky flag.
                cnt1_next    = '0;
                cnt2_next    = '0;
                idx1_next    = '0;
                idx2_next    = '0;
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt1_reg    <= '0;
            cnt2_reg    <= '0;
            idx1_reg    <= '0;
            idx2_reg    <= '0;
            dropped_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            cnt1_reg    <= cnt1_next;
            cnt2_reg    <= cnt2_next;
            idx1_reg    <= idx1_next;
            idx2_reg    <= idx2_next;
            dropped_reg <= dropped_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
        ovf_reg   <= ovf_next;
    end

    assign strobe       = strobe_reg;
    assign merged_value = value_reg;
    assign last         = last_reg;
    assign empty_res    = empty_reg;
    assign overflow     = ovf_reg;

endmodule

`default_nettype wire

### src/sorted_list_merge.sv
// sorted_list_merge: two-way merge of two sorted lists of signed words.
// Push commands produce no item; busy stays low. The receiver cannot stall
// results. Merge of N > 0 stored words: busy until the last item; each item
// leaves the emit state via the result registers; after each but the last, the
// RAMs read the advanced head in a wait state. Merge of two empty lists: one
// empty-marked item on the next cycle. Reset (rst_n, async) empties both lists
// and clears the sticky overflow flag at once; result data and RAMs stay.
`default_nettype none

module sorted_list_merge
    import slm_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // Command channel: an item is taken when start is high and busy is low.
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [FUNC_W-1:0]        func,
    input  wire logic signed [WORD_W-1:0] value,
    // Result channel: each item is valid for the one cycle strobe is high.
    output logic                          strobe,
    output logic signed [WORD_W-1:0]      merged_value,
    output logic                          last,
    output logic                          empty_res,
    output logic                          overflow
);

    slm_cmd_t    cmd;
    slm_status_t status;

    // The controller decodes commands and paces the merge walk: each step
    // alternates an emit state (compare heads, issue an item, advance one
    // index) with a wait state while the RAMs fetch the new head.
    slm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // The datapath holds both list RAMs, their fill counts, the read heads,
    // the sticky overflow flag and the registered result item.
    slm_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .value        (value),
        .status       (status),
        .strobe       (strobe),
        .merged_value (merged_value),
        .last         (last),
        .empty_res    (empty_res),
        .overflow     (overflow)
    );

endmodule

`default_nettype wire
